// File: rtl/core/directed_cycle_detector_macros.svh
// ----------------------------------------------------------------------------
// directed cycle detector assertion macros
// shared property forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef DIRECTED_CYCLE_DETECTOR_MACROS_SVH
`define DIRECTED_CYCLE_DETECTOR_MACROS_SVH

// same-cycle implication
`define DCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcd: same-cycle check failed");

// next-cycle implication
`define DCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcd: next-cycle check failed");

`endif

// File: rtl/core/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// shared constants, codes and types of the directed cycle detector
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  localparam int unsigned DCD_MAX_NODES = 1024;
  localparam int unsigned DCD_MAX_EDGES = 4096;

  localparam int unsigned NODE_W     = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT   = 1'b0;
  localparam logic [NODE_W-1:0]    NODE_COUNT_RESET = 11'd1;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [1:0] {
    COL_NEW  = 2'd0,
    COL_OPEN = 2'd1,
    COL_DONE = 2'd2
  } colour_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN_START,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_STEP,
    ST_EDGE,
    ST_TGT,
    ST_PUSH,
    ST_POP,
    ST_RESULT
  } walk_state_t;

  typedef struct packed {
    logic colour;
    logic link;
    logic parent;
  } node_we_t;

  typedef struct packed {
    logic    acyclic;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/dcd_ifs.sv
// ----------------------------------------------------------------------------
// dcd channel interfaces
// valid/ready channels for edge and run items and for results
// ----------------------------------------------------------------------------
`default_nettype none

interface dcd_in_if;
  import dcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] dst_node;

  modport source (output valid, output action, output src_node, output dst_node,
                  input ready);
  modport sink   (input valid, input action, input src_node, input dst_node,
                  output ready);
endinterface

interface dcd_out_if;
  import dcd_pkg::*;

  logic                valid;
  logic                ready;
  logic                acyclic;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output acyclic, output status, input ready);
  modport sink   (input valid, input acyclic, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/directed_cycle_detector.sv
// ----------------------------------------------------------------------------
// directed_cycle_detector
// Edge items (action 0) add src_node -> dst_node to adjacency lists kept in
// an edge memory and a node memory. While idle, one edge is taken per cycle;
// the load is a two-stage read-modify-write of the list head with forwarding.
// A run item (action 1) walks the graph depth first and gives one
// result item: acyclic and status (first load error since the previous run).
// Edge items give none. The walk scans the nodes in order, follows the edges
// of each new node, descends into new targets and returns through the stored
// parent; it stops at the first back edge. Each step is bound by the single
// registered read port of the node memory.
// After each result is handed to the output register, and after reset, every
// node memory entry is cleared, one entry per cycle, with in_ch not ready.
// The result sits in an output register; while it is stalled the block goes
// on clearing and loading edges, and a further run waits for the register.
// node_count must be written by the user over the APB port at byte address 0
// only while idle; the block does not enforce it and takes writes throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "directed_cycle_detector_macros.svh"

module directed_cycle_detector #(
  parameter  int unsigned MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter  int unsigned MAX_EDGES = dcd_pkg::DCD_MAX_EDGES,
  localparam int unsigned IDW = $clog2(MAX_NODES + 1),
  localparam int unsigned NAW = $clog2(MAX_NODES),
  localparam int unsigned LKW = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  dcd_in_if.sink                         in_ch,
  dcd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import dcd_pkg::*;

  logic [NODE_W-1:0] node_count;
  logic [IDW-1:0]    node_limit;
  logic              reg_hit;

  logic              res_valid;
  logic              res_ready;
  result_t           res;

  logic              out_valid;
  logic              out_acyclic;
  status_t           out_status;

  logic [NAW-1:0]    nm_rd_addr;
  colour_t           nm_rd_colour;
  logic [LKW-1:0]    nm_rd_link;
  logic [IDW-1:0]    nm_rd_parent;
  logic [NAW-1:0]    nm_wr_addr;
  node_we_t          nm_we;
  colour_t           nm_wr_colour;
  logic [LKW-1:0]    nm_wr_link;
  logic [IDW-1:0]    nm_wr_parent;

  logic [EAW-1:0]    em_rd_addr;
  logic [LKW-1:0]    em_rd_next;
  logic [IDW-1:0]    em_rd_target;
  logic              em_we;
  logic [EAW-1:0]    em_wr_addr;
  logic [LKW-1:0]    em_wr_next;
  logic [IDW-1:0]    em_wr_target;

  // config register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_NODE_COUNT);
  assign prdata  = reg_hit ? APB_DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  assign node_limit = (32'(node_count) > MAX_NODES) ? IDW'(MAX_NODES) : IDW'(node_count);

  // output register
  assign res_ready      = !out_valid || out_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.acyclic = out_acyclic;
  assign out_ch.status  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_acyclic <= res.acyclic;
      out_status  <= res.status;
    end
  end

  dcd_walker #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .node_limit   (node_limit),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .nm_rd_addr   (nm_rd_addr),
    .nm_rd_colour (nm_rd_colour),
    .nm_rd_link   (nm_rd_link),
    .nm_rd_parent (nm_rd_parent),
    .nm_wr_addr   (nm_wr_addr),
    .nm_we        (nm_we),
    .nm_wr_colour (nm_wr_colour),
    .nm_wr_link   (nm_wr_link),
    .nm_wr_parent (nm_wr_parent),
    .em_rd_addr   (em_rd_addr),
    .em_rd_next   (em_rd_next),
    .em_rd_target (em_rd_target),
    .em_we        (em_we),
    .em_wr_addr   (em_wr_addr),
    .em_wr_next   (em_wr_next),
    .em_wr_target (em_wr_target)
  );

  dcd_node_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_node_store (
    .clk       (clk),
    .rd_addr   (nm_rd_addr),
    .rd_colour (nm_rd_colour),
    .rd_link   (nm_rd_link),
    .rd_parent (nm_rd_parent),
    .wr_addr   (nm_wr_addr),
    .we        (nm_we),
    .wr_colour (nm_wr_colour),
    .wr_link   (nm_wr_link),
    .wr_parent (nm_wr_parent)
  );

  dcd_edge_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_store (
    .clk       (clk),
    .rd_addr   (em_rd_addr),
    .rd_next   (em_rd_next),
    .rd_target (em_rd_target),
    .we        (em_we),
    .wr_addr   (em_wr_addr),
    .wr_next   (em_wr_next),
    .wr_target (em_wr_target)
  );

  `DCD_ASSERT_IMP(a_no_item_while_result, res_valid, !in_ch.ready)
  `DCD_ASSERT_IMP(a_out_from_result, $rose(out_ch.valid), $past(res_valid && res_ready))
  `DCD_ASSERT_IMP(a_clear_after_reset, $past(rst), !in_ch.ready)
  `DCD_ASSERT_NEXT(a_clear_after_result, res_valid && res_ready, !in_ch.ready)

endmodule

`default_nettype wire

// File: rtl/core/dcd_node_store.sv
// ----------------------------------------------------------------------------
// dcd_node_store
// per-node memory: colour, list head / walk cursor, parent in the walk
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_node_store #(
  parameter  int unsigned MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter  int unsigned MAX_EDGES = dcd_pkg::DCD_MAX_EDGES,
  localparam int unsigned IDW = $clog2(MAX_NODES + 1),
  localparam int unsigned NAW = $clog2(MAX_NODES),
  localparam int unsigned LKW = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk,
  input  logic [NAW-1:0]    rd_addr,
  output dcd_pkg::colour_t  rd_colour,
  output logic [LKW-1:0]    rd_link,
  output logic [IDW-1:0]    rd_parent,
  input  logic [NAW-1:0]    wr_addr,
  input  dcd_pkg::node_we_t we,
  input  dcd_pkg::colour_t  wr_colour,
  input  logic [LKW-1:0]    wr_link,
  input  logic [IDW-1:0]    wr_parent
);
  import dcd_pkg::*;

  typedef struct packed {
    colour_t        colour;
    logic [LKW-1:0] link;
    logic [IDW-1:0] parent;
  } entry_t;

  entry_t mem [MAX_NODES];
  entry_t rd_q;

  always_ff @(posedge clk) begin
    if (we.colour) begin
      mem[wr_addr].colour <= wr_colour;
    end
    if (we.link) begin
      mem[wr_addr].link <= wr_link;
    end
    if (we.parent) begin
      mem[wr_addr].parent <= wr_parent;
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_colour = rd_q.colour;
  assign rd_link   = rd_q.link;
  assign rd_parent = rd_q.parent;

endmodule

`default_nettype wire

// File: rtl/core/dcd_edge_store.sv
// ----------------------------------------------------------------------------
// dcd_edge_store
// per-edge memory: next link in the source list and target node
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_edge_store #(
  parameter  int unsigned MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter  int unsigned MAX_EDGES = dcd_pkg::DCD_MAX_EDGES,
  localparam int unsigned IDW = $clog2(MAX_NODES + 1),
  localparam int unsigned LKW = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic           clk,
  input  logic [EAW-1:0] rd_addr,
  output logic [LKW-1:0] rd_next,
  output logic [IDW-1:0] rd_target,
  input  logic           we,
  input  logic [EAW-1:0] wr_addr,
  input  logic [LKW-1:0] wr_next,
  input  logic [IDW-1:0] wr_target
);
  typedef struct packed {
    logic [LKW-1:0] next;
    logic [IDW-1:0] target;
  } entry_t;

  entry_t mem [MAX_EDGES];
  entry_t rd_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= '{next: wr_next, target: wr_target};
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_next   = rd_q.next;
  assign rd_target = rd_q.target;

endmodule

`default_nettype wire

// File: rtl/core/dcd_walker.sv
// ----------------------------------------------------------------------------
// dcd_walker
// edge load pipeline, depth-first walk sequencer and node store clearing
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_walker #(
  parameter  int unsigned MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter  int unsigned MAX_EDGES = dcd_pkg::DCD_MAX_EDGES,
  localparam int unsigned IDW = $clog2(MAX_NODES + 1),
  localparam int unsigned NAW = $clog2(MAX_NODES),
  localparam int unsigned LKW = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  dcd_in_if.sink            in_ch,
  input  logic [IDW-1:0]    node_limit,
  output logic              res_valid,
  input  logic              res_ready,
  output dcd_pkg::result_t  res,
  output logic [NAW-1:0]    nm_rd_addr,
  input  dcd_pkg::colour_t  nm_rd_colour,
  input  logic [LKW-1:0]    nm_rd_link,
  input  logic [IDW-1:0]    nm_rd_parent,
  output logic [NAW-1:0]    nm_wr_addr,
  output dcd_pkg::node_we_t nm_we,
  output dcd_pkg::colour_t  nm_wr_colour,
  output logic [LKW-1:0]    nm_wr_link,
  output logic [IDW-1:0]    nm_wr_parent,
  output logic [EAW-1:0]    em_rd_addr,
  input  logic [LKW-1:0]    em_rd_next,
  input  logic [IDW-1:0]    em_rd_target,
  output logic              em_we,
  output logic [EAW-1:0]    em_wr_addr,
  output logic [LKW-1:0]    em_wr_next,
  output logic [IDW-1:0]    em_wr_target
);
  import dcd_pkg::*;

  localparam int unsigned SCW = $clog2(MAX_NODES + 2);

  walk_state_t    state, state_next;
  logic [NAW-1:0] clr_addr, clr_addr_next;
  logic [LKW-1:0] edges_stored, edges_stored_next;
  status_t        load_error, load_error_next;

  logic           ld_valid, ld_valid_next;
  logic [NAW-1:0] ld_addr, ld_addr_next;
  logic [IDW-1:0] ld_dst, ld_dst_next;
  logic [EAW-1:0] ld_slot, ld_slot_next;
  logic           fwd_valid, fwd_valid_next;
  logic [NAW-1:0] fwd_addr, fwd_addr_next;
  logic [LKW-1:0] fwd_link, fwd_link_next;

  logic [SCW-1:0] scan_i, scan_i_next;
  logic [IDW-1:0] top_node, top_node_next;
  logic [LKW-1:0] top_cur, top_cur_next;
  logic [IDW-1:0] top_parent, top_parent_next;
  logic [IDW-1:0] tgt, tgt_next;
  logic           acyclic, acyclic_next;

  logic           in_accept;
  logic           src_ok;
  logic           dst_ok;
  logic [LKW-1:0] ld_link;
  logic [LKW-1:0] ld_head;

  function automatic logic [NAW-1:0] id_addr(input logic [IDW-1:0] id);
    return NAW'(id - IDW'(1));
  endfunction

  assign in_ch.ready = (state == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign src_ok = (in_ch.src_node != '0) && (32'(in_ch.src_node) <= 32'(node_limit));
  assign dst_ok = (in_ch.dst_node != '0) && (32'(in_ch.dst_node) <= 32'(node_limit));

  // forward the head written at the same edge as this read
  assign ld_link = LKW'(ld_slot) + LKW'(1);
  assign ld_head = (fwd_valid && (fwd_addr == ld_addr)) ? fwd_link : nm_rd_link;

  assign res.acyclic = acyclic;
  assign res.status  = load_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      edges_stored <= '0;
      load_error   <= STATUS_OK;
      ld_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      edges_stored <= edges_stored_next;
      load_error   <= load_error_next;
      ld_valid     <= ld_valid_next;
      fwd_valid    <= fwd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr    <= ld_addr_next;
    ld_dst     <= ld_dst_next;
    ld_slot    <= ld_slot_next;
    fwd_addr   <= fwd_addr_next;
    fwd_link   <= fwd_link_next;
    scan_i     <= scan_i_next;
    top_node   <= top_node_next;
    top_cur    <= top_cur_next;
    top_parent <= top_parent_next;
    tgt        <= tgt_next;
    acyclic    <= acyclic_next;
  end

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    edges_stored_next = edges_stored;
    load_error_next   = load_error;
    ld_valid_next     = 1'b0;
    ld_addr_next      = ld_addr;
    ld_dst_next       = ld_dst;
    ld_slot_next      = ld_slot;
    fwd_valid_next    = ld_valid;
    fwd_addr_next     = ld_addr;
    fwd_link_next     = ld_link;
    scan_i_next       = scan_i;
    top_node_next     = top_node;
    top_cur_next      = top_cur;
    top_parent_next   = top_parent;
    tgt_next          = tgt;
    acyclic_next      = acyclic;

    nm_rd_addr   = '0;
    nm_wr_addr   = '0;
    nm_we        = '0;
    nm_wr_colour = COL_NEW;
    nm_wr_link   = '0;
    nm_wr_parent = '0;
    em_rd_addr   = '0;
    em_we        = 1'b0;
    em_wr_addr   = ld_slot;
    em_wr_next   = ld_head;
    em_wr_target = ld_dst;
    res_valid    = 1'b0;

    // second stage of an edge load: link the new edge in front of its list
    if (ld_valid) begin
      em_we      = 1'b1;
      nm_wr_addr = ld_addr;
      nm_we.link = 1'b1;
      nm_wr_link = ld_link;
    end

    case (state)
      ST_CLEAR: begin
        nm_wr_addr = clr_addr;
        nm_we      = '1;
        if (clr_addr == NAW'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + NAW'(1);
        end
      end
      ST_IDLE: begin
        nm_rd_addr = id_addr(IDW'(in_ch.src_node));
        if (in_accept) begin
          if (in_ch.action == ACT_RUN) begin
            state_next = ST_RUN_START;
          end else if (!(src_ok && dst_ok)) begin
            if (load_error == STATUS_OK) begin
              load_error_next = STATUS_RANGE;
            end
          end else if (edges_stored >= LKW'(MAX_EDGES)) begin
            if (load_error == STATUS_OK) begin
              load_error_next = STATUS_FULL;
            end
          end else begin
            ld_valid_next     = 1'b1;
            ld_addr_next      = id_addr(IDW'(in_ch.src_node));
            ld_dst_next       = IDW'(in_ch.dst_node);
            ld_slot_next      = EAW'(edges_stored);
            edges_stored_next = edges_stored + LKW'(1);
          end
        end
      end
      ST_RUN_START: begin
        scan_i_next = SCW'(1);
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        if (32'(scan_i) > 32'(node_limit)) begin
          acyclic_next = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          nm_rd_addr = NAW'(scan_i - SCW'(1));
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (nm_rd_colour == COL_NEW) begin
          nm_wr_addr      = NAW'(scan_i - SCW'(1));
          nm_we.colour    = 1'b1;
          nm_we.parent    = 1'b1;
          nm_wr_colour    = COL_OPEN;
          nm_wr_parent    = '0;
          top_node_next   = IDW'(scan_i);
          top_cur_next    = nm_rd_link;
          top_parent_next = '0;
          state_next      = ST_STEP;
        end else begin
          scan_i_next = scan_i + SCW'(1);
          state_next  = ST_SCAN;
        end
      end
      ST_STEP: begin
        if (top_cur == '0) begin
          nm_wr_addr   = id_addr(top_node);
          nm_we.colour = 1'b1;
          nm_wr_colour = COL_DONE;
          if (top_parent == '0) begin
            scan_i_next = scan_i + SCW'(1);
            state_next  = ST_SCAN;
          end else begin
            nm_rd_addr = id_addr(top_parent);
            state_next = ST_POP;
          end
        end else begin
          em_rd_addr = EAW'(top_cur - LKW'(1));
          state_next = ST_EDGE;
        end
      end
      ST_POP: begin
        top_node_next   = top_parent;
        top_cur_next    = nm_rd_link;
        top_parent_next = nm_rd_parent;
        state_next      = ST_STEP;
      end
      ST_EDGE: begin
        top_cur_next = em_rd_next;
        tgt_next     = em_rd_target;
        nm_rd_addr   = id_addr(em_rd_target);
        state_next   = ST_TGT;
      end
      ST_TGT: begin
        if (nm_rd_colour == COL_OPEN) begin
          acyclic_next = 1'b0;
          state_next   = ST_RESULT;
        end else if (nm_rd_colour == COL_NEW) begin
          // save the parent's cursor, descend into the target
          nm_wr_addr      = id_addr(top_node);
          nm_we.link      = 1'b1;
          nm_wr_link      = top_cur;
          top_parent_next = top_node;
          top_node_next   = tgt;
          top_cur_next    = nm_rd_link;
          state_next      = ST_PUSH;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_PUSH: begin
        nm_wr_addr   = id_addr(top_node);
        nm_we.colour = 1'b1;
        nm_we.parent = 1'b1;
        nm_wr_colour = COL_OPEN;
        nm_wr_parent = top_parent;
        state_next   = ST_STEP;
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          edges_stored_next = '0;
          load_error_next   = STATUS_OK;
          clr_addr_next     = '0;
          state_next        = ST_CLEAR;
        end
      end
      default: begin
        clr_addr_next = '0;
        state_next    = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: dv/tb_directed_cycle_detector.sv
// ----------------------------------------------------------------------------
// tb_directed_cycle_detector
// feeds edge and run items to the detector with bursty input and a stalling
// receiver, works out verdicts not given by directed rows with a depth-first
// walk of its own and compares result items field by field in arrival order
// ----------------------------------------------------------------------------
module tb_directed_cycle_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import dcd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned LOAD_SETTLE  = 8;
  localparam int unsigned LONG_HOLD    = 2500;
  localparam int unsigned STALL_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 2 * DCD_MAX_NODES + 64;

  typedef enum {ROW_CFG, ROW_EDGE, ROW_RUN} row_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned a;
    int unsigned b;
    bit          given;
    logic        acyclic;
    status_t     status;
  } row_t;

  typedef struct {
    bit      given;
    result_t verdict;
  } answer_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dcd_in_if  in_bus();
  dcd_out_if out_bus();

  directed_cycle_detector DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // graph kept by the predictor
  logic [NODE_W-1:0] cfg_nodes;
  int unsigned       list_first [DCD_MAX_NODES];
  int unsigned       list_link  [DCD_MAX_EDGES];
  int unsigned       edge_dst   [DCD_MAX_EDGES];
  colour_t           mark       [DCD_MAX_NODES];
  int unsigned       path_node  [DCD_MAX_NODES];
  int unsigned       path_cursor[DCD_MAX_NODES];
  int unsigned       edges_held;
  status_t           held_status;

  result_t     verdict_q[$];
  answer_t     answer_q[$];
  result_t     predicted;
  result_t     due;
  answer_t     answer;
  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_served = 0;
  row_t        dir_rows[29];

  always #6 clk = ~clk;

  function int unsigned effective_nodes();
    return (cfg_nodes > DCD_MAX_NODES) ? DCD_MAX_NODES : cfg_nodes;
  endfunction

  function void forget_graph();
    for (int unsigned i = 0; i < DCD_MAX_NODES; i++) begin
      list_first[i] = 0;
      mark[i]       = COL_NEW;
    end
    edges_held  = 0;
    held_status = STATUS_OK;
  endfunction

  function void add_edge(input int unsigned src, input int unsigned dst);
    int unsigned n;
    n = effective_nodes();
    if (src == 0 || src > n || dst == 0 || dst > n) begin
      if (held_status == STATUS_OK) held_status = STATUS_RANGE;
    end else if (edges_held >= DCD_MAX_EDGES) begin
      if (held_status == STATUS_OK) held_status = STATUS_FULL;
    end else begin
      edge_dst[edges_held]  = dst;
      list_link[edges_held] = list_first[src-1];
      list_first[src-1]     = edges_held + 1;
      edges_held++;
    end
  endfunction

  // iterative walk from one root; true on an edge back into the open path
  function bit cycle_from(input int unsigned root);
    int unsigned depth;
    int unsigned cur;
    int unsigned t;
    mark[root-1]   = COL_OPEN;
    path_node[0]   = root;
    path_cursor[0] = list_first[root-1];
    depth = 1;
    while (depth > 0) begin
      cur = path_cursor[depth-1];
      if (cur == 0) begin
        mark[path_node[depth-1]-1] = COL_DONE;
        depth--;
      end else begin
        path_cursor[depth-1] = list_link[cur-1];
        t = edge_dst[cur-1];
        if (mark[t-1] == COL_OPEN) return 1'b1;
        if (mark[t-1] == COL_NEW && depth < DCD_MAX_NODES) begin
          mark[t-1]          = COL_OPEN;
          path_node[depth]   = t;
          path_cursor[depth] = list_first[t-1];
          depth++;
        end
      end
    end
    return 1'b0;
  endfunction

  function result_t judge_graph();
    result_t     r;
    int unsigned n;
    int unsigned i;
    n         = effective_nodes();
    r.acyclic = 1'b1;
    r.status  = held_status;
    i = 1;
    while (r.acyclic && i <= n) begin
      if (mark[i-1] == COL_NEW && cycle_from(i)) r.acyclic = 1'b0;
      i++;
    end
    forget_graph();
    return r;
  endfunction

  task automatic send_item(input logic action, input int unsigned src,
                           input int unsigned dst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                              : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid    <= 1'b1;
    in_bus.action   <= action;
    in_bus.src_node <= src[NODE_W-1:0];
    in_bus.dst_node <= dst[NODE_W-1:0];
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  task automatic request_verdict();
    answer_t free_answer;
    free_answer.given   = 1'b0;
    free_answer.verdict = '0;
    answer_q = {answer_q, free_answer};
    send_item(ACT_RUN, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  task automatic await_verdicts();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned value);
    logic [APB_DATA_W-1:0] word;
    word    = value & 32'h7FF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NODE_COUNT, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_nodes = word[NODE_W-1:0];
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== word) begin
      errors++;
      $display("%0t: node_count readback mismatch, expected %0d, actual %0d",
               $time, word, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_graph(input int unsigned edge_cnt);
    int unsigned n;
    int unsigned shape;
    int unsigned flip_at;
    int unsigned s;
    int unsigned d;
    int unsigned bad;
    int unsigned good;
    n       = effective_nodes();
    shape   = $urandom_range(0, 9);
    flip_at = $urandom_range(0, (edge_cnt > 0) ? edge_cnt - 1 : 0);
    for (int unsigned i = 0; i < edge_cnt; i++) begin
      if (n == 0 || $urandom_range(0, 24) == 0) begin
        bad  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 2047);
        good = (n == 0) ? $urandom_range(0, 2047) : $urandom_range(1, n);
        if ($urandom_range(0, 1)) begin
          s = bad;
          d = good;
        end else begin
          s = good;
          d = bad;
        end
      end else if (n == 1) begin
        s = 1;
        d = 1;
      end else if (shape >= 7) begin
        s = $urandom_range(1, n);
        d = $urandom_range(1, n);
      end else if (shape >= 4 && i == flip_at) begin
        s = $urandom_range(1, n);
        d = $urandom_range(1, s);
      end else begin
        s = $urandom_range(1, n - 1);
        d = $urandom_range(s + 1, n);
      end
      send_item(ACT_EDGE, s, d);
    end
    request_verdict();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.action == ACT_EDGE) begin
          add_edge(in_bus.src_node, in_bus.dst_node);
        end else begin
          predicted = judge_graph();
          answer    = answer_q.pop_front();
          verdict_q = {verdict_q, (answer.given ? answer.verdict : predicted)};
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual acyclic %0b status %0d",
                   $time, out_bus.acyclic, out_bus.status);
        end else begin
          due = verdict_q.pop_front();
          if (out_bus.acyclic !== due.acyclic) begin
            errors++;
            $display("%0t: acyclic mismatch, expected %0b, actual %0b",
                     $time, due.acyclic, out_bus.acyclic);
          end
          if (out_bus.status !== due.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, due.status, out_bus.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned phase;
    out_bus.ready = 1'b0;
    mode_left     = 0;
    phase         = 0;
    mode          = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_OPEN:         out_bus.ready <= 1'b1;
        RX_COIN:         out_bus.ready <= $urandom_range(0, 1);
        RX_EVERY_FOURTH: out_bus.ready <= (phase % 4 == 0);
        default:         out_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    row_t        row;
    answer_t     fixed;
    int unsigned random_goal;
    int unsigned pick;
    int unsigned value;
    clk             = 1'b0;
    rst             = 1'b1;
    in_bus.valid    = 1'b0;
    in_bus.action   = ACT_EDGE;
    in_bus.src_node = '0;
    in_bus.dst_node = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cfg_nodes       = NODE_COUNT_RESET;
    forget_graph();
    dir_rows = '{
      '{ROW_RUN,  2047, 2047, 1'b1, 1'b1, STATUS_OK},
      '{ROW_EDGE, 1,    1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b0, STATUS_OK},
      '{ROW_EDGE, 0,    1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1,    0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1,    2,    1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b1, STATUS_RANGE},
      '{ROW_CFG,  0,    0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1,    1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b1, STATUS_RANGE},
      '{ROW_CFG,  1024, 0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1024, 1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1,    1024, 1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b0, STATUS_OK},
      '{ROW_EDGE, 2047, 3,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1,    2,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 2,    3,    1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b1, STATUS_RANGE},
      '{ROW_CFG,  2047, 0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1025, 1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 1024, 1024, 1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b0, STATUS_RANGE},
      '{ROW_CFG,  8,    0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 5,    6,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 6,    7,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 7,    8,    1'b0, 1'b0, STATUS_OK},
      '{ROW_EDGE, 8,    6,    1'b0, 1'b0, STATUS_OK},
      '{ROW_CFG,  5,    0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_RUN,  0,    0,    1'b1, 1'b0, STATUS_OK}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      case (row.kind)
        ROW_CFG: begin
          await_verdicts();
          set_node_count(row.a);
        end
        ROW_EDGE: begin
          send_item(ACT_EDGE, row.a, row.b);
        end
        default: begin
          fixed.given           = row.given;
          fixed.verdict.acyclic = row.acyclic;
          fixed.verdict.status  = row.status;
          answer_q = {answer_q, fixed};
          send_item(ACT_RUN, row.a, row.b);
        end
      endcase
    end

    // receiver holds off while several graphs queue up behind the result
    await_verdicts();
    set_node_count(12);
    hold_reqs++;
    repeat (4) random_graph($urandom_range(4, 20));
    await_verdicts();

    // chain through every node closed back to the first
    set_node_count(DCD_MAX_NODES);
    for (int unsigned k = 1; k < DCD_MAX_NODES; k++) send_item(ACT_EDGE, k, k + 1);
    send_item(ACT_EDGE, DCD_MAX_NODES, 1);
    request_verdict();

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      value = 0;
        else if (pick == 1) value = 1;
        else if (pick == 2) value = DCD_MAX_NODES;
        else if (pick == 3) value = $urandom_range(DCD_MAX_NODES + 1, 2047);
        else if (pick < 8)  value = $urandom_range(17, 300);
        else                value = $urandom_range(2, 16);
        await_verdicts();
        set_node_count(value);
      end
      random_graph(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                              : $urandom_range(0, 24));
    end

    await_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items, %0d results and %0d node_count writes",
             items_sent, results_seen, cfg_writes);
    $display("including a 1024-deep walk, bad node ids and a long output stall");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dcd_pkg.sv
rtl/core/dcd_ifs.sv
rtl/core/dcd_node_store.sv
rtl/core/dcd_edge_store.sv
rtl/core/dcd_walker.sv
rtl/core/directed_cycle_detector.sv
dv/tb_directed_cycle_detector.sv
